// ===== src/mvc_pkg.sv =====
// mvc_pkg: types, register indexes and constants of the multi-voice chorus
// depends on nothing; used by the interfaces, mvc_div, the core and the testbench
package mvc_pkg;

    typedef logic signed [15:0] t_sample;
    typedef logic [2:0]         t_cfg_idx;
    typedef logic [63:0]        t_cfg_data;

    // configuration register indexes
    localparam t_cfg_idx REG_IN_GAIN  = 3'd0;
    localparam t_cfg_idx REG_OUT_GAIN = 3'd1;
    localparam t_cfg_idx REG_VOICES   = 3'd2;
    localparam t_cfg_idx REG_DLY_LEN  = 3'd3;
    localparam t_cfg_idx REG_DECAYS   = 3'd4;
    localparam t_cfg_idx REG_DEPTHS   = 3'd5;
    localparam t_cfg_idx REG_LFO_LENS = 3'd6;

    // register reset values
    localparam logic [15:0] RST_GAIN     = 16'd13107;
    localparam logic [2:0]  RST_VOICES   = 3'd1;
    localparam logic [12:0] RST_DLY_LEN  = 13'd1024;
    localparam logic [63:0] RST_LFO_LENS = 64'h0001_0001_0001_0001;

    // sine polynomial coefficients, q15 domain
    localparam logic [15:0] SIN_A = 16'd51472;
    localparam logic [15:0] SIN_B = 16'd21024;
    localparam logic [17:0] SIN_C = 18'd2320;

    // request to the shared divider
    typedef struct packed {
        logic        start;
        logic [15:0] rem_init;
        logic [15:0] bits;
        logic [4:0]  count;
        logic [15:0] divisor;
    } t_div_req;

endpackage

// ===== src/mvc_if.sv =====
// mvc_if: valid/ready channels of the multi-voice chorus
// depends on mvc_pkg for the payload types
interface mvc_in_if;
    import mvc_pkg::*;
    logic    valid;
    logic    ready;
    logic    channel;
    t_sample sample_in;
    modport source(output valid, channel, sample_in, input ready);
    modport sink(input valid, channel, sample_in, output ready);
endinterface

interface mvc_out_if;
    import mvc_pkg::*;
    logic    valid;
    logic    ready;
    logic    channel_out;
    t_sample sample_out;
    modport source(output valid, channel_out, sample_out, input ready);
    modport sink(input valid, channel_out, sample_out, output ready);
endinterface

interface mvc_cfg_if;
    import mvc_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_idx  index;
    t_cfg_data data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== src/mvc_div.sv =====
// mvc_div: restoring divider, one quotient bit per cycle
// depends on mvc_pkg for the request struct
module mvc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mvc_pkg::t_div_req i_req,
    output logic              o_busy,
    output logic [15:0]       o_quot,
    output logic [15:0]       o_rem
);
    import mvc_pkg::*;

    logic [4:0]  r_cnt;
    logic [15:0] r_rem;
    logic [15:0] r_bits;
    logic [15:0] r_quot;
    logic [16:0] shifted;
    logic        fits;

    assign shifted = {r_rem, r_bits[15]};
    assign fits    = shifted >= {1'b0, i_req.divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 5'd0;
        end else if (i_req.start) begin
            r_cnt <= i_req.count;
        end else if (r_cnt != 5'd0) begin
            r_cnt <= r_cnt - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.rem_init;
            r_bits <= i_req.bits;
            r_quot <= 16'd0;
        end else if (r_cnt != 5'd0) begin
            r_rem  <= fits ? 16'(shifted - {1'b0, i_req.divisor}) : shifted[15:0];
            r_bits <= {r_bits[14:0], 1'b0};
            r_quot <= {r_quot[14:0], fits};
        end
    end

    assign o_busy = r_cnt != 5'd0;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

// ===== src/mvc_mul.sv =====
// mvc_mul: shared signed multiplier with registered product
// depends on nothing
module mvc_mul (
    input  logic               i_clk,
    input  logic signed [35:0] i_a,
    input  logic signed [17:0] i_b,
    output logic signed [53:0] o_p
);
    logic signed [53:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ===== src/multi_voice_chorus_effect_core.sv =====
// multi_voice_chorus_effect_core: chorus with up to four sine-modulated voices
// depends on mvc_pkg, mvc_if, mvc_div and mvc_mul
//
//  port    dir  word                        handshake
//  i_in    in   channel, sample_in          valid/ready
//  o_out   out  channel_out, sample_out     valid/ready, registered
//  i_cfg   in   index, data                 valid/ready, always ready
//
// each word takes, per voice, a 16-step phase division, six passes through
// the shared multiplier, a 12-step offset modulo and the delay store read,
// all on the one divider and one multiplier
// after reset the delay store is swept to zero, all CHANNELS * MAX_DELAY entries,
// with i_in held not ready; config writes are taken throughout
// a finished word waits in the output register; the core then accepts the
// next input word and computes it while the output stalls, and holds in
// S_PUSH only while the output register still carries the previous word
module multi_voice_chorus_effect_core #(
    parameter int CHANNELS  = 2,
    parameter int MAX_DELAY = 4096,
    parameter int VOICES    = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mvc_in_if.sink      i_in,
    mvc_out_if.source   o_out,
    mvc_cfg_if.sink     i_cfg
);
    import mvc_pkg::*;

    localparam int DEPTH   = CHANNELS * MAX_DELAY;
    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PN      = CHANNELS * VOICES;
    localparam int PIW     = (PN > 1) ? $clog2(PN) : 1;
    localparam logic [12:0] LEN_CAP = 13'((MAX_DELAY > 8191) ? 8191 : MAX_DELAY);
    localparam logic [2:0]  NV_CAP  = 3'((VOICES < 4) ? VOICES : 4);

    // sequencer states
    localparam logic [4:0] S_CLR    = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_DRY    = 5'd2;
    localparam logic [4:0] S_DRYA   = 5'd3;
    localparam logic [4:0] S_VSTART = 5'd4;
    localparam logic [4:0] S_PDIV   = 5'd5;
    localparam logic [4:0] S_M1     = 5'd6;
    localparam logic [4:0] S_M2     = 5'd7;
    localparam logic [4:0] S_M3     = 5'd8;
    localparam logic [4:0] S_M4     = 5'd9;
    localparam logic [4:0] S_M5     = 5'd10;
    localparam logic [4:0] S_M6     = 5'd11;
    localparam logic [4:0] S_MOD    = 5'd12;
    localparam logic [4:0] S_RD     = 5'd13;
    localparam logic [4:0] S_ACC    = 5'd14;
    localparam logic [4:0] S_FIN    = 5'd15;
    localparam logic [4:0] S_OUT    = 5'd16;
    localparam logic [4:0] S_PUSH   = 5'd17;

    // configuration registers
    logic [15:0] r_ig, r_og;
    logic [2:0]  r_vc;
    logic [12:0] r_dl;
    logic [63:0] r_dec;
    logic [47:0] r_dep;
    logic [63:0] r_lfo;

    // sequencer and per-word working registers
    logic [4:0]         r_state, n_state;
    logic [AW-1:0]      r_clr;
    t_sample            r_x;
    logic               r_ch;
    logic [CW-1:0]      r_c;
    logic [12:0]        r_len, r_wp, r_idx;
    logic [2:0]         r_nv;
    logic [1:0]         r_v;
    logic signed [35:0] r_acc;
    logic [15:0]        r_ph, r_llen, r_z, r_z2;
    logic [1:0]         r_q;
    t_sample            r_y;

    // per-channel state
    logic [15:0] r_phase [PN];
    logic [12:0] r_wpos  [CHANNELS];

    // output register
    logic    r_ovalid;
    logic    r_och;
    t_sample r_osamp;

    // delay store
    logic signed [15:0] mem [DEPTH];
    logic signed [15:0] r_rd;

    // shared units
    t_div_req           div_req;
    logic               div_busy;
    logic [15:0]        div_quot, div_rem;
    logic signed [35:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [53:0] prod;

    mvc_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_busy (div_busy),
        .o_quot (div_quot),
        .o_rem  (div_rem)
    );

    mvc_mul u_mul (
        .i_clk(i_clk),
        .i_a  (mul_a),
        .i_b  (mul_b),
        .o_p  (prod)
    );

    logic in_fire;
    assign in_fire = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    // input-time clamps
    logic [CW-1:0] c_in;
    logic [12:0]   len_in, wp_raw, wp_in;
    logic [2:0]    nv_in;
    assign c_in   = (CHANNELS > 1) ? CW'(i_in.channel) : CW'(0);
    assign len_in = (r_dl == 13'd0) ? 13'd1 : ((r_dl > LEN_CAP) ? LEN_CAP : r_dl);
    assign nv_in  = (r_vc > NV_CAP) ? NV_CAP : r_vc;
    assign wp_raw = r_wpos[c_in];
    assign wp_in  = (wp_raw >= len_in) ? 13'd0 : wp_raw;

    // per-voice fields and phase
    logic [PIW-1:0] pidx;
    logic [15:0]    llen_raw, llen_c, ph_raw, ph_c, decay;
    logic [11:0]    depth;
    assign pidx     = PIW'(32'(r_c) * VOICES + 32'(r_v));
    assign llen_raw = r_lfo[16*r_v +: 16];
    assign llen_c   = (llen_raw == 16'd0) ? 16'd1 : llen_raw;
    assign ph_raw   = r_phase[pidx];
    assign ph_c     = (ph_raw >= llen_c) ? 16'd0 : ph_raw;
    assign decay    = r_dec[16*r_v +: 16];
    assign depth    = r_dep[12*r_v +: 12];

    // quadrant fold of the turn fraction
    logic [1:0]  q_c;
    logic [14:0] r_frac;
    logic [15:0] z_c;
    assign q_c    = div_quot[15:14];
    assign r_frac = {div_quot[13:0], 1'b0};
    assign z_c    = (q_c == 2'd0 || q_c == 2'd2) ? {1'b0, r_frac}
                                                 : 16'(17'd32768 - {2'b0, r_frac});

    // sine polynomial steps, taken off the product register
    logic [15:0] z2_c, s1_c, s2_c;
    logic [16:0] y_c, m_c, u_c;
    logic [28:0] off_sum;
    logic [11:0] off_c;
    assign z2_c    = prod[30:15];
    assign s1_c    = SIN_B - {3'b0, prod[27:15]};
    assign s2_c    = SIN_A - prod[30:15];
    assign y_c     = prod[31:15];
    assign m_c     = (y_c > 17'd32768) ? 17'd32768 : y_c;
    assign u_c     = (r_q < 2'd2) ? 17'd32768 + m_c : 17'd32768 - m_c;
    assign off_sum = prod[28:0] + 29'd32768;
    assign off_c   = off_sum[27:16];

    // read index behind the write position
    logic [13:0] idx_sum;
    logic [12:0] idx_c;
    assign idx_sum = {1'b0, r_wp} + {1'b0, r_len} - {1'b0, div_rem[12:0]};
    assign idx_c   = (idx_sum >= {1'b0, r_len}) ? 13'(idx_sum - {1'b0, r_len})
                                                : idx_sum[12:0];

    // final scale, round half up, saturate
    logic signed [53:0] t_round;
    logic signed [23:0] y_wide;
    t_sample            y_sat;
    assign t_round = prod + 54'sd536870912;
    assign y_wide  = 24'(t_round >>> 30);
    assign y_sat   = (y_wide > 24'sd32767) ? 16'sh7fff :
                     (y_wide < -24'sd32768) ? 16'sh8000 : y_wide[15:0];

    // phase step
    logic [16:0] ph_inc;
    logic [15:0] ph_next;
    assign ph_inc  = {1'b0, r_ph} + 17'd1;
    assign ph_next = (ph_inc >= {1'b0, r_llen}) ? 16'd0 : ph_inc[15:0];

    logic [12:0] wp_inc;
    assign wp_inc = (13'(r_wp + 13'd1) >= r_len) ? 13'd0 : 13'(r_wp + 13'd1);

    // store addresses
    logic [AW-1:0] ch_base;
    assign ch_base = AW'(32'(r_c) * MAX_DELAY);

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR:    if (r_clr == AW'(DEPTH - 1)) n_state = S_IDLE;
            S_IDLE:   if (in_fire) n_state = S_DRY;
            S_DRY:    n_state = S_DRYA;
            S_DRYA:   n_state = (r_nv == 3'd0) ? S_FIN : S_VSTART;
            S_VSTART: n_state = S_PDIV;
            S_PDIV:   if (!div_busy) n_state = S_M1;
            S_M1:     n_state = S_M2;
            S_M2:     n_state = S_M3;
            S_M3:     n_state = S_M4;
            S_M4:     n_state = S_M5;
            S_M5:     n_state = S_M6;
            S_M6:     n_state = S_MOD;
            S_MOD:    if (!div_busy) n_state = S_RD;
            S_RD:     n_state = S_ACC;
            S_ACC:    n_state = (3'({1'b0, r_v} + 3'd1) < r_nv) ? S_VSTART : S_FIN;
            S_FIN:    n_state = S_OUT;
            S_OUT:    n_state = S_PUSH;
            S_PUSH:   if (!r_ovalid || o_out.ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // divider requests: phase fraction, then offset modulo
    always_comb begin
        div_req = '0;
        case (r_state)
            S_VSTART: begin
                div_req.start    = 1'b1;
                div_req.rem_init = ph_c;
                div_req.bits     = 16'd0;
                div_req.count    = 5'd16;
                div_req.divisor  = llen_c;
            end
            S_M6: begin
                div_req.start    = 1'b1;
                div_req.rem_init = 16'd0;
                div_req.bits     = {off_c, 4'b0};
                div_req.count    = 5'd12;
                div_req.divisor  = {3'b0, r_len};
            end
            S_PDIV: div_req.divisor = r_llen;
            S_MOD:  div_req.divisor = {3'b0, r_len};
            default: div_req = '0;
        endcase
    end

    // multiplier operands per step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_DRY: begin
                mul_a = 36'(r_x);
                mul_b = {2'b0, r_ig};
            end
            S_M1: begin
                mul_a = {20'b0, r_z};
                mul_b = {2'b0, r_z};
            end
            S_M2: begin
                mul_a = {20'b0, z2_c};
                mul_b = SIN_C;
            end
            S_M3: begin
                mul_a = {20'b0, s1_c};
                mul_b = {2'b0, r_z2};
            end
            S_M4: begin
                mul_a = {20'b0, s2_c};
                mul_b = {2'b0, r_z};
            end
            S_M5: begin
                mul_a = {24'b0, depth};
                mul_b = {1'b0, u_c};
            end
            S_RD: begin
                mul_a = 36'(r_rd);
                mul_b = {2'b0, decay};
            end
            S_FIN: begin
                mul_a = r_acc;
                mul_b = {2'b0, r_og};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < PN; i++) r_phase[i] <= 16'd0;
            for (int i = 0; i < CHANNELS; i++) r_wpos[i] <= 13'd0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) r_clr <= AW'(r_clr + AW'(1));
            if (r_state == S_M6) r_phase[pidx] <= ph_next;
            if (r_state == S_OUT) r_wpos[r_c] <= wp_inc;
            // a new word loaded while the old one leaves keeps valid high
            if (r_state == S_PUSH && (!r_ovalid || o_out.ready)) begin
                r_ovalid <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ig  <= RST_GAIN;
            r_og  <= RST_GAIN;
            r_vc  <= RST_VOICES;
            r_dl  <= RST_DLY_LEN;
            r_dec <= 64'd0;
            r_dep <= 48'd0;
            r_lfo <= RST_LFO_LENS;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_IN_GAIN:  r_ig  <= i_cfg.data[15:0];
                REG_OUT_GAIN: r_og  <= i_cfg.data[15:0];
                REG_VOICES:   r_vc  <= i_cfg.data[2:0];
                REG_DLY_LEN:  r_dl  <= i_cfg.data[12:0];
                REG_DECAYS:   r_dec <= i_cfg.data;
                REG_DEPTHS:   r_dep <= i_cfg.data[47:0];
                REG_LFO_LENS: r_lfo <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // working payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_x   <= i_in.sample_in;
                r_ch  <= i_in.channel;
                r_c   <= c_in;
                r_len <= len_in;
                r_nv  <= nv_in;
                r_wp  <= wp_in;
                r_v   <= 2'd0;
            end
            S_DRYA:   r_acc <= prod[35:0];
            S_VSTART: begin
                r_ph   <= ph_c;
                r_llen <= llen_c;
            end
            S_PDIV: begin
                r_q <= q_c;
                r_z <= z_c;
            end
            S_M2:  r_z2 <= z2_c;
            S_MOD: r_idx <= idx_c;
            S_ACC: begin
                r_acc <= r_acc + prod[35:0];
                r_v   <= 2'(r_v + 2'd1);
            end
            S_OUT: r_y <= y_sat;
            default: ;
        endcase
    end

    // delay store: clearing sweep, sample write, tap read
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLR) begin
            mem[r_clr] <= 16'sd0;
        end else if (r_state == S_OUT) begin
            mem[AW'(ch_base + AW'(r_wp))] <= r_x;
        end
        if (r_state == S_MOD) begin
            r_rd <= mem[AW'(ch_base + AW'(idx_c))];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (r_state == S_PUSH && (!r_ovalid || o_out.ready)) begin
            r_och   <= r_ch;
            r_osamp <= r_y;
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.channel_out = r_och;
    assign o_out.sample_out  = r_osamp;

    // divider is never left running when a new word comes in
    a_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !div_busy)
        else $error("divider busy while idle");

    // tap read index stays inside the delay line
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> (r_idx < r_len))
        else $error("tap index beyond delay length");

    // voice counter stays below the active voice count
    a_voice_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> ({1'b0, r_v} < r_nv))
        else $error("voice index beyond active count");

    // write position stays inside the delay line
    a_wp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_wp < r_len))
        else $error("write position beyond delay length");

    // an accepted word always starts with the dry multiply
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == S_DRY))
        else $error("accepted word did not start");

endmodule

// ===== test/tb_mvc_chorus_model.sv =====
`timescale 1ns / 1ps
// chorus_model: expected-output model and output checker for the chorus core
// depends on mvc_pkg for the register indexes
class chorus_model;
    int unsigned in_gain, post_gain, n_voices, dly_len;
    bit [63:0]   decays, lfo_lens;
    bit [47:0]   depths;
    shortint     store[2][4096];
    int unsigned wr_pos[2];
    int unsigned phase[2][4];
    bit [16:0]   pending_out[$];
    int          mismatches;

    function new();
        in_gain = 13107; post_gain = 13107; n_voices = 1; dly_len = 1024;
        decays = 0; depths = 0; lfo_lens = 64'h0001_0001_0001_0001;
        foreach (store[c, i]) store[c][i] = 0;
        wr_pos = '{0, 0};
        foreach (phase[c, v]) phase[c][v] = 0;
        mismatches = 0;
    endfunction

    function void write_reg(int idx, bit [63:0] d);
        case (idx)
            mvc_pkg::REG_IN_GAIN:  in_gain   = d[15:0];
            mvc_pkg::REG_OUT_GAIN: post_gain = d[15:0];
            mvc_pkg::REG_VOICES:   n_voices  = d[2:0];
            mvc_pkg::REG_DLY_LEN:  dly_len   = d[12:0];
            mvc_pkg::REG_DECAYS:   decays    = d;
            mvc_pkg::REG_DEPTHS:   depths    = d[47:0];
            mvc_pkg::REG_LFO_LENS: lfo_lens  = d;
            default: ;
        endcase
    endfunction

    // |sin| polynomial in q15
    function longint unsigned sine_abs(longint unsigned z);
        longint unsigned z2, s, y;
        z2 = (z * z) >> 15;
        s = 21024 - ((2320 * z2) >> 15);
        s = 51472 - ((s * z2) >> 15);
        y = (s * z) >> 15;
        return (y > 32768) ? 32768 : y;
    endfunction

    function int unsigned voice_offset(int unsigned ph, int unsigned llen,
                                       int unsigned depth);
        longint unsigned p, q, r, z, m, u;
        p = ({32'd0, ph} << 16) / llen;
        q = (p >> 14) & 3;
        r = (p & 16383) << 1;
        z = (q == 0 || q == 2) ? r : 32768 - r;
        m = sine_abs(z);
        u = (q < 2) ? 32768 + m : 32768 - m;
        return (depth * u + 32768) >> 16;
    endfunction

    // mix one input word and queue the expected output word
    function void note_input(bit ch, shortint x);
        int unsigned len, nv, wp, llen, off, idx;
        longint acc, t, y;
        len = (dly_len == 0) ? 1 : (dly_len > 4096 ? 4096 : dly_len);
        nv = (n_voices > 4) ? 4 : n_voices;
        wp = (wr_pos[ch] >= len) ? 0 : wr_pos[ch];
        acc = longint'(x) * in_gain;
        for (int v = 0; v < nv; v++) begin
            llen = lfo_lens[16*v +: 16];
            if (llen == 0) llen = 1;
            if (phase[ch][v] >= llen) phase[ch][v] = 0;
            off = voice_offset(phase[ch][v], llen, depths[12*v +: 12]) % len;
            idx = (wp + len - off) % len;
            acc += longint'(store[ch][idx]) * longint'(decays[16*v +: 16]);
            phase[ch][v] = (phase[ch][v] + 1 >= llen) ? 0 : phase[ch][v] + 1;
        end
        t = acc * post_gain + (64'sd1 << 29);
        y = t >>> 30;
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
        store[ch][wp] = x;
        wr_pos[ch] = (wp + 1 >= len) ? 0 : wp + 1;
        pending_out.push_back({ch, 16'(y)});
    endfunction

    function void check_output(bit ch, bit [15:0] s);
        bit [16:0] exp_w;
        if (pending_out.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected output ch=%0d s=%0d", ch, $signed(s));
            return;
        end
        exp_w = pending_out.pop_front();
        if (exp_w != {ch, s}) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp ch=%0d s=%0d, got ch=%0d s=%0d", exp_w[16],
                         $signed(exp_w[15:0]), ch, $signed(s));
        end
    endfunction
endclass

// ===== test/tb_multi_voice_chorus_effect_core.sv =====
`timescale 1ns / 1ps
// tb_multi_voice_chorus_effect_core: random and directed test of the chorus core
// depends on mvc_pkg, mvc_if, the core and the chorus_model class
module tb_multi_voice_chorus_effect_core;
    import mvc_pkg::*;

    logic i_clk;
    logic i_rst_n;
    mvc_in_if  in_ch();
    mvc_out_if out_ch();
    mvc_cfg_if cfg_ch();

    chorus_model model = new();
    // random wait between output words, redrawn per word
    int unsigned out_gap;

    multi_voice_chorus_effect_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in(in_ch.sink), .o_out(out_ch.source), .i_cfg(cfg_ch.sink)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // generous limit: reset sweep plus 1724 words and both stalls
    initial begin
        #4000000;
        $display("multi_voice_chorus_effect_core test failed");
        $finish;
    end

    // write one register, block idle
    task automatic write_cfg(t_cfg_idx idx, logic [63:0] d);
        @(negedge i_clk);
        cfg_ch.valid <= 1; cfg_ch.index <= idx; cfg_ch.data <= d;
        do @(posedge i_clk); while (!cfg_ch.ready);
        model.write_reg(idx, d);
        @(negedge i_clk);
        cfg_ch.valid <= 0;
    endtask

    // send one input word after a random gap; valid stays up for a word that
    // follows with no gap and is dropped by the next gap or by drain
    task automatic send_word(bit ch, logic [15:0] s, bit no_gap);
        int unsigned gap;
        gap = no_gap ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            in_ch.valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1; in_ch.channel <= ch; in_ch.sample_in <= s;
        do @(posedge i_clk); while (!in_ch.ready);
        model.note_input(ch, s);
        @(negedge i_clk);
    endtask

    // wait until every expected word is back, then a latency pause
    task automatic drain();
        in_ch.valid <= 0;
        while (model.pending_out.size() != 0) @(negedge i_clk);
        repeat (250) @(negedge i_clk);
    endtask

    task automatic random_config(bit extreme);
        write_cfg(REG_IN_GAIN, extreme ? ($urandom_range(0, 1) ? 16'd32768 : 16'd0)
                                       : $urandom_range(0, 32768));
        write_cfg(REG_OUT_GAIN, extreme ? 16'd32768 : $urandom_range(0, 32768));
        write_cfg(REG_VOICES, $urandom_range(0, 7));
        write_cfg(REG_DLY_LEN, $urandom_range(0, 3) == 0 ? $urandom_range(4090, 8191)
                                                         : $urandom_range(0, 64));
        write_cfg(REG_DECAYS, {$urandom, $urandom});
        write_cfg(REG_DEPTHS, {$urandom, $urandom});
        // mostly short lfo periods so phases wrap, sometimes zero or long
        write_cfg(REG_LFO_LENS, {16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)),
                                 16'($urandom), 16'($urandom_range(0, 3))});
    endtask

    // output side: random stall then accept one word
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 0;
            out_gap = 0;
        end else if (out_ch.ready && out_ch.valid) begin
            out_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            out_ch.ready <= (out_gap == 0);
        end else if (out_gap != 0) begin
            out_gap--;
            out_ch.ready <= (out_gap == 0);
        end else begin
            out_ch.ready <= 1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            model.check_output(out_ch.channel_out, out_ch.sample_out);
    end

    initial begin
        logic [15:0] edge_vals[6];
        int unsigned burst;
        edge_vals = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA};
        i_rst_n = 0;
        in_ch.valid = 0; in_ch.channel = 0; in_ch.sample_in = 0;
        cfg_ch.valid = 0; cfg_ch.index = REG_IN_GAIN; cfg_ch.data = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1;

        // directed: reset settings, then full gains, four voices, tiny delay
        foreach (edge_vals[i]) send_word(i[0], edge_vals[i], 0);
        drain();
        write_cfg(REG_IN_GAIN, 16'd32768);
        write_cfg(REG_OUT_GAIN, 16'd32768);
        write_cfg(REG_VOICES, 3'd4);
        write_cfg(REG_DLY_LEN, 13'd3);
        write_cfg(REG_DECAYS, 64'hFFFF_8000_7FFF_FFFF);
        write_cfg(REG_DEPTHS, 48'hFFF_FFF_007_000);
        write_cfg(REG_LFO_LENS, 64'h0000_0004_0007_FFFF);
        foreach (edge_vals[i]) send_word(i[1], edge_vals[i], i[0]);
        foreach (edge_vals[i]) send_word(!i[1], edge_vals[5 - i], 0);
        drain();
        // delay length zero and above max, voice count zero and clamped
        write_cfg(REG_DLY_LEN, 13'd0);
        write_cfg(REG_VOICES, 3'd0);
        send_word(0, 16'h7FFF, 0); send_word(1, 16'h8000, 0);
        drain();
        write_cfg(REG_DLY_LEN, 13'd8191);
        write_cfg(REG_VOICES, 3'd7);
        write_cfg(REG_LFO_LENS, 64'h0002_0000_0005_0003);
        repeat (4) send_word(1, 16'h8000, 0);
        drain();

        // random phases, each with a fresh setting
        for (int ph = 0; ph < 17; ph++) begin
            random_config(ph % 5 == 0);
            burst = 100;
            for (int n = 0; n < burst; n++)
                send_word($urandom_range(0, 1), $urandom_range(0, 7) == 0
                          ? edge_vals[$urandom_range(0, 5)] : 16'($urandom),
                          $urandom_range(0, 4) == 0);
            drain();
        end

        if (model.mismatches == 0 && model.pending_out.size() == 0)
            $display("multi_voice_chorus_effect_core test passed");
        else
            $display("multi_voice_chorus_effect_core test failed");
        $finish;
    end
endmodule

// ===== sim.f =====
src/mvc_pkg.sv
src/mvc_if.sv
src/mvc_div.sv
src/mvc_mul.sv
src/multi_voice_chorus_effect_core.sv
test/tb_mvc_chorus_model.sv
test/tb_multi_voice_chorus_effect_core.sv
